// ===== sv/rarl_pkg.sv =====
// Package for the rule action rate limiter: widths, codes, table entry and update types.
// No dependencies; used by every other file of the block but rarl_ram.
package rarl_pkg;

  localparam int unsigned NumRulesDef = 1024;

  localparam int unsigned OpW     = 2;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned ActW    = 16;
  localparam int unsigned CntW    = 32;
  localparam int unsigned TickW   = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  localparam logic [ActW-1:0] RateFlagRst = ActW'(1);
  localparam logic [ActW-1:0] AllowRst    = '0;

  typedef enum logic [OpW-1:0] {
    OpAdd   = 2'd0,
    OpDel   = 2'd1,
    OpMatch = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRateFlag = 1'd0,
    CfgAllow    = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [CntW-1:0]  limit;
    logic [ActW-1:0]  exceed;
    logic [CntW-1:0]  count;
    logic [TickW-1:0] wstart;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic            wr;
    entry_t          word;
    logic            has_rsp;
    logic [ActW-1:0] action;
    logic            limit_hit;
  } upd_t;

endpackage

// ===== sv/rarl_if.sv =====
// Handshake channels of the rule action rate limiter: rule operations in, decisions out.
// Depends on rarl_pkg for the field widths.
interface rarl_item_if import rarl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OpW-1:0]        opcode;
  logic [IdxW-1:0]       rule_index;
  logic [ActW-1:0]       action_mask;
  logic [CntW-1:0]       rate_limit;
  logic [ActW-1:0]       over_limit_action;
  logic [TickW-1:0]      now_ticks;

  modport source (output valid, opcode, rule_index, action_mask, rate_limit,
                  over_limit_action, now_ticks, input ready);
  modport sink   (input valid, opcode, rule_index, action_mask, rate_limit,
                  over_limit_action, now_ticks, output ready);
endinterface

interface rarl_result_if import rarl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ActW-1:0] decided_action;
  logic            limit_hit;

  modport source (output valid, decided_action, limit_hit, input ready);
  modport sink   (input valid, decided_action, limit_hit, output ready);
endinterface

// ===== sv/rarl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rarl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rarl_update.sv =====
// Read-modify-write step of one rule entry: add, delete and fixed-window match.
// Depends on rarl_pkg.
module rarl_update import rarl_pkg::*; (
  input  logic [OpW-1:0]   op_i,
  input  logic             idx_ok_i,
  input  logic [ActW-1:0]  mask_i,
  input  logic [CntW-1:0]  limit_i,
  input  logic [ActW-1:0]  exceed_i,
  input  logic [TickW-1:0] now_i,
  input  logic [ActW-1:0]  rate_flag_i,
  input  logic [ActW-1:0]  allow_i,
  input  entry_t           cur_i,
  output upd_t             upd_o
);

  logic [CntW-1:0] cnt_inc;

  assign cnt_inc = (cur_i.count == '1) ? cur_i.count : cur_i.count + CntW'(1);

  always_comb begin
    upd_o           = '0;
    upd_o.word      = cur_i;
    upd_o.action    = allow_i;
    case (op_i)
      OpAdd: begin
        if (idx_ok_i) begin
          upd_o.wr          = 1'b1;
          upd_o.word.action = mask_i;
          if ((mask_i & rate_flag_i) != '0) begin
            upd_o.word.count  = '0;
            upd_o.word.limit  = limit_i;
            upd_o.word.exceed = exceed_i;
          end
        end
      end
      OpDel: begin
        if (idx_ok_i) begin
          upd_o.wr          = 1'b1;
          upd_o.word.count  = '0;
          upd_o.word.action = allow_i;
        end
      end
      OpMatch: begin
        upd_o.has_rsp = 1'b1;
        if (idx_ok_i) begin
          if ((cur_i.action & rate_flag_i) == '0) begin
            upd_o.action = cur_i.action;
          end else if (now_i > cur_i.wstart) begin
            upd_o.wr          = 1'b1;
            upd_o.word.wstart = now_i;
            upd_o.word.count  = CntW'(1);
          end else begin
            upd_o.wr         = 1'b1;
            upd_o.word.count = cnt_inc;
            if (cnt_inc > cur_i.limit) begin
              upd_o.action    = cur_i.exceed;
              upd_o.limit_hit = 1'b1;
            end
          end
        end
      end
      default: begin
        upd_o.has_rsp = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/rule_action_rate_limiter_unit.sv =====
// Rule action table with a fixed-window rate limiter per rule; one item per cycle unless a
// held result stalls the update stage, whose result is registered. After reset a clearing
// pass writes every entry, one per cycle, during which no item is taken. The single-cycle
// rate is set by the entry read-modify-write loop, closed by forwarding the last write.
// Depends on rarl_pkg, rarl_if, rarl_ram and rarl_update.
module rule_action_rate_limiter_unit import rarl_pkg::*; #(
  parameter int unsigned NumRules = NumRulesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  rarl_item_if.sink          item_i,
  rarl_result_if.source      result_o
);

  localparam int unsigned AddrW = (NumRules > 1) ? $clog2(NumRules) : 1;
  localparam logic [16:0] IdxLimit = 17'(NumRules);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(NumRules - 1);

  logic [ActW-1:0] rate_flag_q, allow_q;

  logic             clearing_q;
  logic [AddrW-1:0] clr_cnt_q;

  logic              s1_valid_q;
  logic [OpW-1:0]    s1_op_q;
  logic              s1_idx_ok_q;
  logic [AddrW-1:0]  s1_addr_q;
  logic [ActW-1:0]   s1_mask_q;
  logic [CntW-1:0]   s1_limit_q;
  logic [ActW-1:0]   s1_exceed_q;
  logic [TickW-1:0]  s1_now_q;

  logic   fwd_valid_q, fwd_valid_d;
  entry_t fwd_word_q;

  logic            out_valid_q;
  logic [ActW-1:0] out_action_q;
  logic            out_hit_q;

  logic             accept, out_free, s1_adv, wr_fire, out_load, in_idx_ok;
  logic [AddrW-1:0] in_addr;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  entry_t           cur_word;
  upd_t             upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_flag_q <= RateFlagRst;
      allow_q     <= AllowRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgRateFlag: rate_flag_q <= cfg_data_i;
        CfgAllow:    allow_q     <= cfg_data_i;
        default:     rate_flag_q <= rate_flag_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == LastAddr) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_adv       = s1_valid_q && (upd.has_rsp ? out_free : 1'b1);
  assign item_i.ready = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept       = item_i.valid && item_i.ready;
  assign wr_fire      = s1_adv && upd.wr;
  assign out_load     = s1_adv && upd.has_rsp;
  assign in_addr      = AddrW'(item_i.rule_index);
  assign in_idx_ok    = {7'd0, item_i.rule_index} < IdxLimit;
  assign fwd_valid_d  = wr_fire && (s1_addr_q == in_addr);
  assign cur_word     = fwd_valid_q ? fwd_word_q : entry_t'(ram_rdata);

  assign ram_we    = clearing_q || wr_fire;
  assign ram_waddr = clearing_q ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = clearing_q ? '0 : upd.word;

  rarl_ram #(
    .Width (EntryW),
    .Depth (NumRules)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  rarl_update u_update (
    .op_i        (s1_op_q),
    .idx_ok_i    (s1_idx_ok_q),
    .mask_i      (s1_mask_q),
    .limit_i     (s1_limit_q),
    .exceed_i    (s1_exceed_q),
    .now_i       (s1_now_q),
    .rate_flag_i (rate_flag_q),
    .allow_i     (allow_q),
    .cur_i       (cur_word),
    .upd_o       (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q  <= 1'b1;
        fwd_valid_q <= fwd_valid_d;
      end else if (s1_adv) begin
        s1_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= item_i.opcode;
      s1_idx_ok_q <= in_idx_ok;
      s1_addr_q   <= in_addr;
      s1_mask_q   <= item_i.action_mask;
      s1_limit_q  <= item_i.rate_limit;
      s1_exceed_q <= item_i.over_limit_action;
      s1_now_q    <= item_i.now_ticks;
      fwd_word_q  <= upd.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_action_q <= upd.action;
      out_hit_q    <= upd.limit_hit;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.decided_action = out_action_q;
  assign result_o.limit_hit      = out_hit_q;

  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !accept)
    else $error("item transfer during clearing pass");

  a_no_stage_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s1_valid_q)
    else $error("entry update pending during clearing pass");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fwd_valid_d) |=> (fwd_valid_q && $past(wr_fire)))
    else $error("forwarded word without a preceding write");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten while held");

  a_hit_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && upd.limit_hit) |-> (s1_op_q == OpMatch && s1_idx_ok_q))
    else $error("limit hit reported outside a match");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for rule_action_rate_limiter_unit: directed table, then random phases.
// Predicts decisions from a copy of the rule table and configuration, or a typed directed row.
// Depends on rarl_pkg, rarl_if and the block's RTL.
module tb;
  import rarl_pkg::*;

  localparam int unsigned NumRules      = NumRulesDef;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned ItemsPerPhase = 160;
  localparam int unsigned IdleSettle    = 8;
  localparam int unsigned HoldAt        = 150;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned NumDirected   = 25;
  localparam int unsigned NumHot        = 6;

  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [IdxW-1:0]  idx;
    logic [ActW-1:0]  mask;
    logic [CntW-1:0]  limit;
    logic [ActW-1:0]  exceed;
    logic [TickW-1:0] now;
  } rule_op_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic            hit;
  } verdict_t;

  typedef struct packed {
    rule_op_t item;
    logic     typed;
    verdict_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_data;

  rarl_item_if   item_if ();
  rarl_result_if res_if ();

  rule_action_rate_limiter_unit #(.NumRules(NumRules)) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_if),
    .result_o   (res_if)
  );

  logic [ActW-1:0]  tbl_action [NumRules];
  logic [CntW-1:0]  tbl_limit  [NumRules];
  logic [ActW-1:0]  tbl_exceed [NumRules];
  logic [CntW-1:0]  tbl_count  [NumRules];
  logic [TickW-1:0] tbl_wstart [NumRules];
  logic [ActW-1:0]  rate_cfg;
  logic [ActW-1:0]  allow_cfg;

  verdict_t         decisions_due [$];
  logic [IdxW-1:0]  hot_idx [NumHot];
  logic [TickW-1:0] tick_base;
  bit               src_burst;
  bit               sink_burst;
  int unsigned      fail_count;
  int unsigned      n_items;
  int unsigned      n_checked;
  int unsigned      n_hits;
  int unsigned      cycles = 0;

  dir_row_t dir_tab [NumDirected] = '{
    '{'{OpMatch,  10'd0,    16'h0000, 32'h0,        16'h0000, 32'h0},        1'b1, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd1023, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF}, 1'b1, '{16'h0000, 1'b0}},
    '{'{OpAdd,    10'd5,    16'h0001, 32'd2,        16'hBEEF, 32'h0},        1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd5,    16'h0000, 32'h0,        16'h0000, 32'd100},      1'b1, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd5,    16'h0000, 32'h0,        16'h0000, 32'd100},      1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd5,    16'h0000, 32'h0,        16'h0000, 32'd50},       1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd5,    16'h0000, 32'h0,        16'h0000, 32'd101},      1'b0, '{16'h0000, 1'b0}},
    '{'{OpAdd,    10'd6,    16'hFFFE, 32'd3,        16'h5555, 32'h0},        1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd6,    16'h0000, 32'h0,        16'h0000, 32'd7},        1'b1, '{16'hFFFE, 1'b0}},
    '{'{OpAdd,    10'd7,    16'hFFFF, 32'h0,        16'hFFFF, 32'h0},        1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd7,    16'h0000, 32'h0,        16'h0000, 32'h0},        1'b1, '{16'hFFFF, 1'b1}},
    '{'{OpDel,    10'd7,    16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF}, 1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd7,    16'h0000, 32'h0,        16'h0000, 32'h0},        1'b1, '{16'h0000, 1'b0}},
    '{'{OpAdd,    10'd1023, 16'h0001, 32'hFFFFFFFF, 16'h1234, 32'h0},        1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd1023, 16'h0000, 32'h0,        16'h0000, 32'h0},        1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd1023, 16'h0000, 32'h0,        16'h0000, 32'hFFFFFFFF}, 1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd1023, 16'h0000, 32'h0,        16'h0000, 32'hFFFFFFFF}, 1'b0, '{16'h0000, 1'b0}},
    '{'{OpUnused, 10'd5,    16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF}, 1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd5,    16'h0000, 32'h0,        16'h0000, 32'd101},      1'b0, '{16'h0000, 1'b0}},
    '{'{OpAdd,    10'd5,    16'h0003, 32'h0,        16'h0000, 32'h0},        1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd5,    16'h0000, 32'h0,        16'h0000, 32'd101},      1'b0, '{16'h0000, 1'b0}},
    '{'{OpDel,    10'd5,    16'h0000, 32'h0,        16'h0000, 32'h0},        1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd5,    16'h0000, 32'h0,        16'h0000, 32'd200},      1'b0, '{16'h0000, 1'b0}},
    '{'{OpAdd,    10'd0,    16'h0000, 32'hFFFFFFFF, 16'hFFFF, 32'h0},        1'b0, '{16'h0000, 1'b0}},
    '{'{OpMatch,  10'd0,    16'h0000, 32'h0,        16'h0000, 32'd1},        1'b1, '{16'h0000, 1'b0}}
  };

  function automatic bit rate_flagged(input logic [ActW-1:0] m);
    return (m & rate_cfg) != '0;
  endfunction

  // update the table copy; return 1 with the decision when the operation yields one
  function automatic bit rule_decide(input rule_op_t it, output verdict_t v);
    logic [IdxW-1:0] i;
    i = it.idx;
    v.action = allow_cfg;
    v.hit    = 1'b0;
    case (it.op)
      OpAdd: begin
        tbl_action[i] = it.mask;
        if (rate_flagged(it.mask)) begin
          tbl_count[i]  = '0;
          tbl_limit[i]  = it.limit;
          tbl_exceed[i] = it.exceed;
        end
        return 1'b0;
      end
      OpDel: begin
        tbl_count[i]  = '0;
        tbl_action[i] = allow_cfg;
        return 1'b0;
      end
      OpMatch: begin
        if (!rate_flagged(tbl_action[i])) begin
          v.action = tbl_action[i];
        end else if (it.now > tbl_wstart[i]) begin
          tbl_wstart[i] = it.now;
          tbl_count[i]  = CntW'(1);
        end else begin
          if (tbl_count[i] != '1) tbl_count[i] = tbl_count[i] + 1'b1;
          if (tbl_count[i] > tbl_limit[i]) begin
            v.action = tbl_exceed[i];
            v.hit    = 1'b1;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned idle_draw(input bit burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic rule_op_t draw_op();
    rule_op_t    it;
    int unsigned r;
    it.idx    = ($urandom_range(0, 99) < 85) ? hot_idx[$urandom_range(0, NumHot-1)]
                                              : IdxW'($urandom);
    it.mask   = ActW'($urandom);
    it.limit  = $urandom;
    it.exceed = ActW'($urandom);
    it.now    = $urandom;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      it.op = OpAdd;
      r = $urandom_range(0, 99);
      if (r < 60) it.mask = it.mask | rate_cfg;
      else if (r < 75) it.mask = it.mask & ~rate_cfg;
      r = $urandom_range(0, 99);
      if (r < 70) it.limit = $urandom_range(0, 4);
      else if (r < 80) it.limit = '1;
    end else if (r < 33) begin
      it.op = OpDel;
    end else if (r < 37) begin
      it.op = OpUnused;
    end else begin
      it.op = OpMatch;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it.now = tick_base;
      end else if (r < 70) begin
        tick_base = tick_base + $urandom_range(1, 3);
        it.now    = tick_base;
      end else if (r < 85) begin
        it.now = tick_base - $urandom_range(1, 4);
      end else if (r < 90) begin
        it.now = '0;
      end else if (r < 95) begin
        it.now = '1;
      end
    end
    return it;
  endfunction

  function automatic void log_fail(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) $display("%0t: %s", $time, msg);
  endfunction

  task automatic send_op(input rule_op_t it);
    int unsigned gap;
    gap = idle_draw(src_burst);
    @(negedge clk);
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.valid             <= 1'b1;
    item_if.opcode            <= it.op;
    item_if.rule_index        <= it.idx;
    item_if.action_mask       <= it.mask;
    item_if.rate_limit        <= it.limit;
    item_if.over_limit_action <= it.exceed;
    item_if.now_ticks         <= it.now;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    n_items++;
  endtask

  task automatic quiet_source();
    @(negedge clk);
    item_if.valid <= 1'b0;
  endtask

  task automatic settle();
    quiet_source();
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (IdleSettle) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CfgW-1:0] rate, input logic [CfgW-1:0] allow);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgRateFlag;
    cfg_data <= rate;
    @(negedge clk);
    cfg_idx  <= CfgAllow;
    cfg_data <= allow;
    @(negedge clk);
    cfg_we   <= 1'b0;
    rate_cfg  = rate;
    allow_cfg = allow;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    verdict_t    got;
    verdict_t    want;
    int unsigned gap;
    res_if.ready = 1'b0;
    sink_burst   = 1'b0;
    forever begin
      gap = idle_draw(sink_burst);
      @(negedge clk);
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      got.action = res_if.decided_action;
      got.hit    = res_if.limit_hit;
      if (got.hit === 1'b1) n_hits++;
      if (decisions_due.size() == 0) begin
        log_fail($sformatf("decision %h/%b with none outstanding", got.action, got.hit));
      end else begin
        want = decisions_due.pop_front();
        if (got.action !== want.action)
          log_fail($sformatf("decision %0d: decided_action expected %h got %h",
                             n_checked, want.action, got.action));
        if (got.hit !== want.hit)
          log_fail($sformatf("decision %0d: limit_hit expected %b got %b",
                             n_checked, want.hit, got.hit));
      end
      n_checked++;
      if (n_checked % 32 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      if (n_checked == HoldAt) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
    end
  end

  initial begin
    rule_op_t    it;
    verdict_t    v;
    logic [CfgW-1:0] rate;
    logic [CfgW-1:0] allow;
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_idx                   = CfgRateFlag;
    cfg_data                  = '0;
    item_if.valid             = 1'b0;
    item_if.opcode            = OpAdd;
    item_if.rule_index        = '0;
    item_if.action_mask       = '0;
    item_if.rate_limit        = '0;
    item_if.over_limit_action = '0;
    item_if.now_ticks         = '0;
    fail_count                = 0;
    n_items                   = 0;
    n_checked                 = 0;
    n_hits                    = 0;
    src_burst                 = 1'b0;
    rate_cfg                  = RateFlagRst;
    allow_cfg                 = AllowRst;
    for (int i = 0; i < NumRules; i++) begin
      tbl_action[i] = AllowRst;
      tbl_limit[i]  = '0;
      tbl_exceed[i] = '0;
      tbl_count[i]  = '0;
      tbl_wstart[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NumDirected; r++) begin
      send_op(dir_tab[r].item);
      if (rule_decide(dir_tab[r].item, v)) begin
        if (dir_tab[r].typed) v = dir_tab[r].want;
        decisions_due.push_back(v);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: begin rate = 16'hFFFF; allow = 16'hFFFF; end
        1: begin rate = 16'h0000; allow = CfgW'($urandom); end
        2: begin rate = 16'h8000; allow = 16'h0000; end
        3: begin rate = CfgW'($urandom); allow = CfgW'($urandom); end
        default: begin rate = RateFlagRst; allow = CfgW'($urandom); end
      endcase
      write_regs(rate, allow);
      for (int k = 0; k < NumHot; k++) hot_idx[k] = IdxW'($urandom);
      tick_base = (ph == 3) ? 32'hFFFF_FFF0 : $urandom_range(0, 50);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (k % 32 == 0) src_burst = ($urandom_range(0, 3) == 0);
        if (k == ItemsPerPhase / 2) begin
          quiet_source();
          while (decisions_due.size() != 0) @(posedge clk);
        end
        it = draw_op();
        send_op(it);
        if (rule_decide(it, v)) decisions_due.push_back(v);
      end
    end

    settle();
    if (decisions_due.size() != 0)
      log_fail($sformatf("%0d decisions never arrived", decisions_due.size()));
    $display("Ran %0d rule operations (%0d directed) across %0d register settings",
             n_items, NumDirected, NumPhases + 1);
    $display("Checked %0d decisions, %0d over the rate limit; %0d failures",
             n_checked, n_hits, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
